[hdl/idhs_pkg.sv]
// shared types and constants for the idle depth hint selector
package idhs_pkg;

    localparam int NUM_CPUS       = 8;
    localparam int MAX_STATES     = 8;
    localparam int IDLE_STEP_US   = 500;
    localparam int CPU_IDX_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    localparam int DATA_W    = 32;
    localparam int CPU_W     = 3;
    localparam int IDX_W     = 3;
    localparam int NIB_W     = 4;
    localparam int HINT_W    = 8;
    localparam int STEP_W    = 9;
    localparam int ITER_W    = 6;
    localparam int PROD_W    = STEP_W + NIB_W;
    localparam int APB_ADDR_W = 3;

    localparam logic [STEP_W-1:0] STEP_NORMAL = STEP_W'(IDLE_STEP_US);
    localparam logic [STEP_W-1:0] STEP_SAVING = STEP_W'(IDLE_STEP_US / 4);
    localparam logic [ITER_W-1:0] ITERS_FULL  = ITER_W'(DATA_W);
    localparam logic [ITER_W-1:0] ITERS_SUB   = ITER_W'(PROD_W);
    localparam logic [ITER_W-1:0] ITERS_LAST  = ITER_W'(1);

    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic REG_POWER_SAVING = 1'b0;
    localparam logic REG_DESCRIPTOR   = 1'b1;

    typedef struct packed {
        logic              power_saving;
        logic [DATA_W-1:0] descriptor;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [STEP_W-1:0] divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [STEP_W-1:0] remainder;
    } div_rsp_t;

endpackage

[hdl/idhs_if.sv]
// request and result channel interfaces
interface idhs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [idhs_pkg::CPU_W-1:0]  cpu;
    logic [idhs_pkg::DATA_W-1:0] slept_time;

    modport source (output valid, output operation, output cpu, output slept_time,
                    input ready);
    modport sink   (input valid, input operation, input cpu, input slept_time,
                    output ready);
endinterface

interface idhs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [idhs_pkg::HINT_W-1:0] hint;
    logic [idhs_pkg::IDX_W-1:0]  state_index;
    logic [idhs_pkg::NIB_W-1:0]  substate;
    logic [idhs_pkg::DATA_W-1:0] average_idle;
    logic                        no_states;

    modport source (output valid, output hint, output state_index, output substate,
                    output average_idle, output no_states, input ready);
    modport sink   (input valid, input hint, input state_index, input substate,
                    input average_idle, input no_states, output ready);
endinterface

[hdl/idhs_cfg.sv]
// apb configuration registers
module idhs_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [idhs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [idhs_pkg::DATA_W-1:0]     pwdata,
    output logic [idhs_pkg::DATA_W-1:0]     prdata,
    output idhs_pkg::cfg_t                  cfg
);

    logic                        power_saving_reg;
    logic [idhs_pkg::DATA_W-1:0] descriptor_reg;
    logic                        reg_sel;
    logic                        wr_en;

    // word addressed: low two bits ignored
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_saving_reg <= 1'b0;
            descriptor_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                idhs_pkg::REG_POWER_SAVING: power_saving_reg <= pwdata[0];
                idhs_pkg::REG_DESCRIPTOR:   descriptor_reg   <= pwdata;
                default:                    power_saving_reg <= power_saving_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            idhs_pkg::REG_POWER_SAVING: prdata = {{(idhs_pkg::DATA_W-1){1'b0}}, power_saving_reg};
            idhs_pkg::REG_DESCRIPTOR:   prdata = descriptor_reg;
            default:                    prdata = '0;
        endcase
    end

    assign cfg.power_saving = power_saving_reg;
    assign cfg.descriptor   = descriptor_reg;

endmodule

[hdl/idhs_div.sv]
// shared restoring divider, one quotient bit per cycle
module idhs_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  idhs_pkg::div_req_t req,
    output idhs_pkg::div_rsp_t rsp
);

    logic                        active_reg;
    logic                        done_reg;
    logic [idhs_pkg::ITER_W-1:0] cnt_reg;
    logic [idhs_pkg::DATA_W-1:0] dvd_reg;
    logic [idhs_pkg::DATA_W-1:0] quo_reg;
    logic [idhs_pkg::STEP_W-1:0] rem_reg;
    logic [idhs_pkg::STEP_W-1:0] divisor_reg;
    logic [idhs_pkg::STEP_W:0]   trial;
    logic                        fits;

    assign trial = {rem_reg, dvd_reg[idhs_pkg::DATA_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= !req.start && active_reg && (cnt_reg == idhs_pkg::ITERS_LAST);
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= req.iters;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == idhs_pkg::ITERS_LAST)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg     <= req.dividend;
            divisor_reg <= req.divisor;
            quo_reg     <= '0;
            rem_reg     <= '0;
        end
        else if (active_reg)
        begin
            dvd_reg <= {dvd_reg[idhs_pkg::DATA_W-2:0], 1'b0};
            quo_reg <= {quo_reg[idhs_pkg::DATA_W-2:0], fits};
            rem_reg <= fits ? idhs_pkg::STEP_W'(trial - {1'b0, divisor_reg})
                            : trial[idhs_pkg::STEP_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hdl/idle_depth_hint_selector_unit.sv]
// idle depth hint selector: top level with sequencer and per-cpu averages
// choose: a full 32-bit pass and a 13-bit pass through the shared divider, plus
//   sequencing; no states listed: straight to the result without the divider
// report: one 33-bit add and halve
// one item at a time; a new item is taken while a result waits
// reset: asynchronous active low, clears averages, configuration registers and control
module idle_depth_hint_selector_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [idhs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [idhs_pkg::DATA_W-1:0]     pwdata,
    output logic [idhs_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    idhs_req_if.sink                        req,
    idhs_rsp_if.source                      rsp
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOADQ = 7'b0000010,
        S_DIVQ  = 7'b0000100,
        S_LOADS = 7'b0001000,
        S_DIVS  = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    idhs_pkg::cfg_t     cfg;
    idhs_pkg::div_req_t div_req;
    idhs_pkg::div_rsp_t div_rsp;

    logic [idhs_pkg::DATA_W-1:0]    avg_mem_reg [idhs_pkg::NUM_CPUS];
    logic [idhs_pkg::DATA_W-1:0]    avg_cur_reg;
    logic [idhs_pkg::DATA_W-1:0]    slept_reg;
    logic [idhs_pkg::CPU_IDX_W-1:0] cpu_idx_reg;
    logic                           cpu_ok_reg;
    logic [idhs_pkg::IDX_W-1:0]     idx_reg;
    logic [idhs_pkg::NIB_W-1:0]     sub_reg;
    logic [idhs_pkg::STEP_W-1:0]    rem_reg;

    logic                           rsp_valid_reg;
    logic [idhs_pkg::HINT_W-1:0]    hint_reg;
    logic [idhs_pkg::IDX_W-1:0]     out_idx_reg;
    logic [idhs_pkg::NIB_W-1:0]     out_sub_reg;
    logic [idhs_pkg::DATA_W-1:0]    out_avg_reg;
    logic                           out_none_reg;

    logic                           accept;
    logic                           out_free;
    logic [idhs_pkg::CPU_IDX_W-1:0] cpu_idx;
    logic                           cpu_ok;
    logic [idhs_pkg::IDX_W-1:0]     state_cnt;
    logic [idhs_pkg::IDX_W-1:0]     last_idx;
    logic [idhs_pkg::NIB_W-1:0]     nib;
    logic [idhs_pkg::NIB_W-1:0]     sel_count;
    logic [idhs_pkg::STEP_W-1:0]    step;
    logic [idhs_pkg::PROD_W-1:0]    prod;
    logic [idhs_pkg::DATA_W:0]      sum;

    idhs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    idhs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pready = 1'b1;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign cpu_idx  = idhs_pkg::CPU_IDX_W'(req.cpu);
    assign cpu_ok   = 32'(req.cpu) < 32'(idhs_pkg::NUM_CPUS);
    assign step     = cfg.power_saving ? idhs_pkg::STEP_SAVING : idhs_pkg::STEP_NORMAL;
    assign last_idx = state_cnt - 1'b1;
    assign prod     = idhs_pkg::PROD_W'(rem_reg) * idhs_pkg::PROD_W'(sel_count);
    assign sum      = {1'b0, avg_cur_reg} + {1'b0, slept_reg};

    // compact the nonzero nibbles above nibble 0 and pick the count at the chosen index
    always_comb
    begin
        state_cnt = '0;
        sel_count = '0;
        nib       = '0;
        for (int i = 1; i < idhs_pkg::MAX_STATES; i++)
        begin
            nib = cfg.descriptor[idhs_pkg::NIB_W*i +: idhs_pkg::NIB_W];
            if (nib != '0)
            begin
                if (state_cnt == idx_reg)
                begin
                    sel_count = nib;
                end
                state_cnt = state_cnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = avg_cur_reg;
        div_req.divisor  = step;
        div_req.iters    = idhs_pkg::ITERS_FULL;
        if (state_reg == S_LOADQ)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_LOADS)
        begin
            // left-align the product so only its bits are walked
            div_req.start    = 1'b1;
            div_req.dividend = {prod, {(idhs_pkg::DATA_W-idhs_pkg::PROD_W){1'b0}}};
            div_req.iters    = idhs_pkg::ITERS_SUB;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == idhs_pkg::OP_REPORT)
                    begin
                        state_next = S_UPD;
                    end
                    else if (state_cnt == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOADQ;
                    end
                end
            end
            S_LOADQ: state_next = S_DIVQ;
            S_DIVQ:  if (div_rsp.done) state_next = S_LOADS;
            S_LOADS: state_next = S_DIVS;
            S_DIVS:  if (div_rsp.done) state_next = S_DONE;
            S_UPD:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < idhs_pkg::NUM_CPUS; i++)
            begin
                avg_mem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD && cpu_ok_reg)
            begin
                avg_mem_reg[cpu_idx_reg] <= sum[idhs_pkg::DATA_W:1];
            end
            if (state_reg == S_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            avg_cur_reg <= cpu_ok ? avg_mem_reg[cpu_idx] : '0;
            slept_reg   <= req.slept_time;
            cpu_idx_reg <= cpu_idx;
            cpu_ok_reg  <= cpu_ok;
            idx_reg     <= '0;
            sub_reg     <= '0;
        end
        if (state_reg == S_DIVQ && div_rsp.done)
        begin
            idx_reg <= (div_rsp.quotient < 32'(last_idx)) ?
                       div_rsp.quotient[idhs_pkg::IDX_W-1:0] : last_idx;
            rem_reg <= div_rsp.remainder;
        end
        if (state_reg == S_DIVS && div_rsp.done)
        begin
            sub_reg <= div_rsp.quotient[idhs_pkg::NIB_W-1:0];
        end
        if (state_reg == S_UPD && cpu_ok_reg)
        begin
            avg_cur_reg <= sum[idhs_pkg::DATA_W:1];
        end
        if (state_reg == S_DONE && out_free)
        begin
            hint_reg     <= {1'b0, idx_reg, sub_reg};
            out_idx_reg  <= idx_reg;
            out_sub_reg  <= sub_reg;
            out_avg_reg  <= avg_cur_reg;
            out_none_reg <= (state_cnt == '0);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hint         = hint_reg;
    assign rsp.state_index  = out_idx_reg;
    assign rsp.substate     = out_sub_reg;
    assign rsp.average_idle = out_avg_reg;
    assign rsp.no_states    = out_none_reg;

endmodule
